// File: sv/lra_pkg.sv
// shared types, codes and constants of the log regression accumulator
// no dependencies; imported by every module of the block
`default_nettype none

package lra_pkg;

  localparam int DEF_FRACTION_BITS = 16;
  localparam int SUM_W = 64;
  localparam int COUNT_W = 40;
  localparam int QUEUE_DEPTH = 2;

  localparam int IN_DATA_W = 376;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 168;
  localparam int OUT_USER_W = 2;

  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  // commands on the input tuser
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_MERGE = 2'd2;
  localparam logic [1:0] CMD_FINISH = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DEGENERATE = 2'd1;
  localparam logic [1:0] ST_ZERO_X = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    K_CLEAR,
    K_SAMPLE,
    K_SKIP,
    K_MERGE,
    K_FINISH
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [31:0]               x_value;
    logic signed [31:0]        y_value;
    logic [15:0]               weight;
    logic signed [SUM_W-1:0]   part_sum_log;
    logic signed [SUM_W-1:0]   part_sum_ylog;
    logic signed [SUM_W-1:0]   part_sum_y;
    logic signed [SUM_W-1:0]   part_sum_logsq;
    logic [COUNT_W-1:0]        part_count;
  } item_t;

  typedef struct packed {
    logic                    done;
    logic                    deg;
    logic                    sat;
    logic signed [SUM_W-1:0] a_coef;
    logic signed [SUM_W-1:0] b_coef;
  } solve_res_t;

endpackage

`default_nettype wire

// File: sv/lra_front.sv
// front end: accepts stream transfers, classifies the command, queues items
// depends on lra_pkg
`default_nettype none

module lra_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [lra_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic [lra_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                                 item_valid,
  output lra_pkg::item_t                       item,
  input  wire logic                            item_pop
);
  import lra_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  item_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [FILL_W-1:0] fill;
  item_t in_item;
  logic push;
  logic pop;

  always_comb begin
    in_item.x_value = s_tdata[31:0];
    in_item.y_value = s_tdata[63:32];
    in_item.weight = s_tdata[79:64];
    in_item.part_sum_log = s_tdata[143:80];
    in_item.part_sum_ylog = s_tdata[207:144];
    in_item.part_sum_y = s_tdata[271:208];
    in_item.part_sum_logsq = s_tdata[335:272];
    in_item.part_count = s_tdata[375:336];
    case (s_tuser)
      CMD_CLEAR: in_item.kind = K_CLEAR;
      CMD_SAMPLE: in_item.kind = (s_tdata[31:0] == 32'd0) ? K_SKIP : K_SAMPLE;
      CMD_MERGE: in_item.kind = K_MERGE;
      default: in_item.kind = K_FINISH;
    endcase
  end

  assign s_tready = (fill != FILL_W'(QUEUE_DEPTH));
  assign item_valid = (fill != '0);
  assign item = slots[rd_ptr];
  assign push = s_tvalid && s_tready;
  assign pop = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: sv/lra_ln.sv
// natural log of an unsigned fixed-point x by repeated squaring of the mantissa
// depends on lra_pkg
`default_nettype none

module lra_ln #(
  parameter int FRACTION_BITS = lra_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [31:0]                x,
  output logic                            done,
  output logic signed [FRACTION_BITS+6:0] ln_value
);
  import lra_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam int LG_W = F + 7;
  localparam int CNT_W = $clog2(F);

  typedef enum logic [1:0] {L_IDLE, L_SQ, L_MUL, L_RND} state_t;

  state_t state;
  logic [31:0] m;
  logic [4:0] p;
  logic [F-1:0] frac;
  logic [CNT_W-1:0] cnt;
  logic lg_neg;
  logic [LG_W+31:0] prod;

  logic [4:0] p_c;
  logic [63:0] sq;
  logic [6:0] pmf;
  logic signed [LG_W-1:0] lg;
  logic [LG_W-1:0] lg_mag;
  logic [LG_W+32:0] rnd_sum;
  logic [LG_W-1:0] ln_mag;

  always_comb begin
    p_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p_c = 5'(i);
    end
    sq = m * m;
    pmf = {2'b00, p} - 7'(F);
    lg = {pmf, frac};
    lg_mag = lg[LG_W-1] ? LG_W'(-lg) : LG_W'(lg);
    rnd_sum = {1'b0, prod} + {{(LG_W+1){1'b0}}, 1'b1, 31'b0};
    ln_mag = rnd_sum[LG_W+31:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) state <= L_SQ;
        end
        L_SQ: begin
          if (cnt == CNT_W'(F - 1)) state <= L_MUL;
        end
        L_MUL: state <= L_RND;
        L_RND: begin
          done <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) begin
          p <= p_c;
          m <= x << (5'd31 - p_c);
          cnt <= '0;
          frac <= '0;
        end
      end
      L_SQ: begin
        // one squaring per cycle gives one fraction bit of log2
        frac <= {frac[F-2:0], sq[63]};
        m <= sq[63] ? sq[63:32] : sq[62:31];
        cnt <= cnt + 1'b1;
      end
      L_MUL: begin
        prod <= lg_mag * LN2_Q32;
        lg_neg <= lg[LG_W-1];
      end
      L_RND: begin
        ln_value <= lg_neg ? -$signed(ln_mag) : $signed(ln_mag);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/lra_solve.sv
// finish engine: exact wide normal equations and two rounded long divisions
// depends on lra_pkg; one shared 32x32 multiplier and one restoring divider
`default_nettype none

module lra_solve #(
  parameter int FRACTION_BITS = lra_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [lra_pkg::SUM_W-1:0] s_log,
  input  wire logic signed [lra_pkg::SUM_W-1:0] s_ylog,
  input  wire logic signed [lra_pkg::SUM_W-1:0] s_y,
  input  wire logic signed [lra_pkg::SUM_W-1:0] s_logsq,
  input  wire logic [lra_pkg::COUNT_W-1:0]      count,
  output lra_pkg::solve_res_t                   res
);
  import lra_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam int W = 2 * SUM_W + 2 * F + 2;
  localparam int N2_W = W + 2;
  localparam int IT_W = $clog2(N2_W);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_COMB, S_CHECK, S_DMAG, S_DSET, S_DITER, S_DFIN, S_DONE
  } state_t;
  typedef enum logic [1:0] {T_D, T_NB, T_NA} tgt_t;
  typedef enum logic [1:0] {SH_0, SH_F, SH_2F} sh_t;

  state_t state;
  logic [2:0] idx;
  logic [1:0] k;
  logic [63:0] mag_n, mag0, mag1, mag2, mag3;
  logic neg0, neg1, neg2, neg3;
  logic [63:0] pp;
  logic [127:0] prod;
  logic signed [W-1:0] d_acc, nb_acc, na_acc;
  logic which;
  logic [W-1:0] dmag, nmag;
  logic qneg;
  logic [N2_W-1:0] n2, d2, rem;
  logic [63:0] q;
  logic big;
  logic [IT_W-1:0] it;

  logic [63:0] opa, opb;
  logic sgn, sub;
  tgt_t tgt;
  sh_t sh;
  logic [31:0] a_half, b_half;
  logic [127:0] pp_sh;
  logic [W-1:0] ext, ext_sh, addend;
  logic signed [W-1:0] tgt_cur, tgt_sum, num_cur;
  logic [N2_W-1:0] rem_sh, rem_sub;
  logic ge;
  logic q_over;
  logic [63:0] q_res;

  always_comb begin
    case (idx)
      3'd0: begin opa = mag_n; opb = mag3; sgn = neg3; sub = 1'b0; tgt = T_D; sh = SH_F; end
      3'd1: begin opa = mag0; opb = mag0; sgn = 1'b0; sub = 1'b1; tgt = T_D; sh = SH_0; end
      3'd2: begin opa = mag_n; opb = mag1; sgn = neg1; sub = 1'b0; tgt = T_NB; sh = SH_2F; end
      3'd3: begin
        opa = mag2; opb = mag0; sgn = neg2 ^ neg0; sub = 1'b1; tgt = T_NB; sh = SH_F;
      end
      3'd4: begin
        opa = mag2; opb = mag3; sgn = neg2 ^ neg3; sub = 1'b0; tgt = T_NA; sh = SH_F;
      end
      default: begin
        opa = mag0; opb = mag1; sgn = neg0 ^ neg1; sub = 1'b1; tgt = T_NA; sh = SH_F;
      end
    endcase
    a_half = k[0] ? opa[63:32] : opa[31:0];
    b_half = k[1] ? opb[63:32] : opb[31:0];
    case (k)
      2'd0: pp_sh = {64'b0, pp};
      2'd3: pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
    ext = {{(W-128){1'b0}}, prod};
    case (sh)
      SH_0: ext_sh = ext;
      SH_F: ext_sh = ext << F;
      default: ext_sh = ext << (2 * F);
    endcase
    addend = (sgn ^ sub) ? W'(-ext_sh) : ext_sh;
    case (tgt)
      T_D: tgt_cur = d_acc;
      T_NB: tgt_cur = nb_acc;
      default: tgt_cur = na_acc;
    endcase
    tgt_sum = tgt_cur + $signed(addend);
    num_cur = which ? na_acc : nb_acc;
    rem_sh = {rem[N2_W-2:0], n2[N2_W-1]};
    ge = (rem_sh >= d2);
    rem_sub = rem_sh - d2;
    q_over = big || (qneg ? (q[63] && (q[62:0] != '0)) : q[63]);
    if (q_over) begin
      q_res = qneg ? SUM_MIN : SUM_MAX;
    end else begin
      q_res = qneg ? -q : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (start) state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: state <= (k == 2'd3) ? S_COMB : S_MUL;
        S_COMB: state <= (idx == 3'd5) ? S_CHECK : S_MUL;
        S_CHECK: state <= ((mag_n == '0) || (d_acc == '0)) ? S_DONE : S_DMAG;
        S_DMAG: state <= S_DSET;
        S_DSET: state <= S_DITER;
        S_DITER: if (it == '0) state <= S_DFIN;
        S_DFIN: state <= which ? S_DONE : S_DMAG;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.done <= 1'b0;
    end else begin
      res.done <= (state == S_DONE);
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          mag_n <= {{(64-COUNT_W){1'b0}}, count};
          mag0 <= s_log[63] ? 64'(-s_log) : 64'(s_log);
          mag1 <= s_ylog[63] ? 64'(-s_ylog) : 64'(s_ylog);
          mag2 <= s_y[63] ? 64'(-s_y) : 64'(s_y);
          mag3 <= s_logsq[63] ? 64'(-s_logsq) : 64'(s_logsq);
          neg0 <= s_log[63];
          neg1 <= s_ylog[63];
          neg2 <= s_y[63];
          neg3 <= s_logsq[63];
          d_acc <= '0;
          nb_acc <= '0;
          na_acc <= '0;
          prod <= '0;
          idx <= '0;
          k <= '0;
          which <= 1'b0;
          res.deg <= 1'b0;
          res.sat <= 1'b0;
          res.a_coef <= '0;
          res.b_coef <= '0;
        end
      end
      S_MUL: pp <= a_half * b_half;
      S_ACC: begin
        prod <= prod + pp_sh;
        k <= k + 1'b1;
      end
      S_COMB: begin
        case (tgt)
          T_D: d_acc <= tgt_sum;
          T_NB: nb_acc <= tgt_sum;
          default: na_acc <= tgt_sum;
        endcase
        prod <= '0;
        idx <= idx + 1'b1;
      end
      S_CHECK: begin
        if ((mag_n == '0) || (d_acc == '0)) res.deg <= 1'b1;
      end
      S_DMAG: begin
        dmag <= d_acc[W-1] ? W'(-d_acc) : W'(d_acc);
        nmag <= num_cur[W-1] ? W'(-num_cur) : W'(num_cur);
        qneg <= (d_acc[W-1] != num_cur[W-1]) && (num_cur != '0);
      end
      S_DSET: begin
        // rounded quotient: floor((2|n| + |d|) / (2|d|))
        n2 <= {1'b0, nmag, 1'b0} + {2'b00, dmag};
        d2 <= {1'b0, dmag, 1'b0};
        rem <= '0;
        q <= '0;
        big <= 1'b0;
        it <= IT_W'(N2_W - 1);
      end
      S_DITER: begin
        n2 <= {n2[N2_W-2:0], 1'b0};
        rem <= ge ? rem_sub : rem_sh;
        q <= {q[62:0], ge};
        big <= big | q[63];
        it <= it - 1'b1;
      end
      S_DFIN: begin
        res.sat <= res.sat | q_over;
        if (which) begin
          res.a_coef <= q_res;
        end else begin
          res.b_coef <= q_res;
        end
        which <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/lra_back.sv
// back end: executes queued commands on the saturating sums, holds the result
// depends on lra_pkg, lra_ln and lra_solve
`default_nettype none

module lra_back #(
  parameter int FRACTION_BITS = lra_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  input  wire lra_pkg::item_t                  item,
  output logic                                 item_pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [lra_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic [lra_pkg::OUT_USER_W-1:0]       m_tuser
);
  import lra_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam int LN_W = F + 7;
  localparam int YLP_W = 32 + LN_W;
  localparam int LQP_W = 2 * LN_W;
  localparam int YL_W = YLP_W - F + 2;
  localparam int LQ_W = LQP_W - F + 2;

  typedef enum logic [3:0] {
    B_IDLE, B_LN, B_T1, B_T2, B_T3, B_ACC, B_FIN, B_OUT
  } state_t;

  state_t state;
  logic signed [SUM_W-1:0] acc_log, acc_ylog, acc_y, acc_logsq;
  logic [COUNT_W-1:0] acc_count;
  logic domain_flag, overflow_flag;

  logic signed [31:0] y_r;
  logic [15:0] w_r;
  logic signed [LN_W-1:0] ln_r;
  logic [YLP_W-1:0] yl_prod;
  logic [LQP_W-1:0] lq_prod;
  logic yl_neg;
  logic signed [YL_W-1:0] yl;
  logic signed [LQ_W-1:0] lq;
  logic signed [SUM_W-1:0] t_ln, t_yl, t_y, t_lq;

  logic signed [LN_W-1:0] ln_value;
  logic ln_done;
  logic ln_start;
  logic solve_start;
  solve_res_t sres;

  logic [31:0] ymag;
  logic [LN_W-1:0] lnmag;
  logic [YLP_W:0] yl_rnd;
  logic [LQP_W:0] lq_rnd;
  logic [YL_W-2:0] yl_mag;
  logic signed [16:0] w_s;
  logic signed [LN_W+16:0] p_ln;
  logic signed [YL_W+16:0] p_yl;
  logic signed [48:0] p_y;
  logic signed [LQ_W+16:0] p_lq;
  logic signed [SUM_W-1:0] b0, b1, b2, b3;
  logic [COUNT_W-1:0] c_add;
  logic [SUM_W:0] r0, r1, r2, r3;
  logic [COUNT_W:0] c_sum;
  logic apply;
  logic ovf_any;
  logic [1:0] status;

  function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] a,
                                             input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
      sat_add = {1'b1, (b[SUM_W-1] ? SUM_MIN : SUM_MAX)};
    end else begin
      sat_add = {1'b0, s};
    end
  endfunction

  lra_ln #(.FRACTION_BITS(FRACTION_BITS)) u_ln (
    .clk      (clk),
    .rst      (rst),
    .start    (ln_start),
    .x        (item.x_value),
    .done     (ln_done),
    .ln_value (ln_value)
  );

  lra_solve #(.FRACTION_BITS(FRACTION_BITS)) u_solve (
    .clk     (clk),
    .rst     (rst),
    .start   (solve_start),
    .s_log   (acc_log),
    .s_ylog  (acc_ylog),
    .s_y     (acc_y),
    .s_logsq (acc_logsq),
    .count   (acc_count),
    .res     (sres)
  );

  assign item_pop = (state == B_IDLE) && item_valid;
  assign ln_start = item_pop && (item.kind == K_SAMPLE);
  assign solve_start = item_pop && (item.kind == K_FINISH);

  always_comb begin
    ymag = y_r[31] ? 32'(-y_r) : 32'(y_r);
    lnmag = ln_r[LN_W-1] ? LN_W'(-ln_r) : LN_W'(ln_r);
    yl_rnd = {1'b0, yl_prod} + ((YLP_W+1)'(1) << (F - 1));
    lq_rnd = {1'b0, lq_prod} + ((LQP_W+1)'(1) << (F - 1));
    yl_mag = yl_rnd[YLP_W:F];
    w_s = {1'b0, w_r};
    p_ln = ln_r * w_s;
    p_yl = yl * w_s;
    p_y = y_r * w_s;
    p_lq = lq * w_s;
    if (state == B_ACC) begin
      b0 = t_ln;
      b1 = t_yl;
      b2 = t_y;
      b3 = t_lq;
      c_add = {{(COUNT_W-16){1'b0}}, w_r};
    end else begin
      b0 = item.part_sum_log;
      b1 = item.part_sum_ylog;
      b2 = item.part_sum_y;
      b3 = item.part_sum_logsq;
      c_add = item.part_count;
    end
    r0 = sat_add(acc_log, b0);
    r1 = sat_add(acc_ylog, b1);
    r2 = sat_add(acc_y, b2);
    r3 = sat_add(acc_logsq, b3);
    c_sum = {1'b0, acc_count} + {1'b0, c_add};
    ovf_any = r0[SUM_W] | r1[SUM_W] | r2[SUM_W] | r3[SUM_W] | c_sum[COUNT_W];
    apply = (state == B_ACC) || (item_pop && (item.kind == K_MERGE));
    if (sres.deg) begin
      status = ST_DEGENERATE;
    end else if (overflow_flag || sres.sat) begin
      status = ST_OVERFLOW;
    end else if (domain_flag) begin
      status = ST_ZERO_X;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      acc_log <= '0;
      acc_ylog <= '0;
      acc_y <= '0;
      acc_logsq <= '0;
      acc_count <= '0;
      domain_flag <= 1'b0;
      overflow_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == B_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (apply) begin
        acc_log <= r0[SUM_W-1:0];
        acc_ylog <= r1[SUM_W-1:0];
        acc_y <= r2[SUM_W-1:0];
        acc_logsq <= r3[SUM_W-1:0];
        acc_count <= c_sum[COUNT_W] ? {COUNT_W{1'b1}} : c_sum[COUNT_W-1:0];
        overflow_flag <= overflow_flag | ovf_any;
      end
      case (state)
        B_IDLE: begin
          if (item_valid) begin
            case (item.kind)
              K_CLEAR: begin
                acc_log <= '0;
                acc_ylog <= '0;
                acc_y <= '0;
                acc_logsq <= '0;
                acc_count <= '0;
                domain_flag <= 1'b0;
                overflow_flag <= 1'b0;
              end
              K_SKIP: domain_flag <= 1'b1;
              K_SAMPLE: state <= B_LN;
              K_FINISH: state <= B_FIN;
              default: ;
            endcase
          end
        end
        B_LN: if (ln_done) state <= B_T1;
        B_T1: state <= B_T2;
        B_T2: state <= B_T3;
        B_T3: state <= B_ACC;
        B_ACC: state <= B_IDLE;
        B_FIN: if (sres.done) state <= B_OUT;
        B_OUT: begin
          if (!m_tvalid || m_tready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // sample datapath and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (ln_start) begin
      y_r <= item.y_value;
      w_r <= item.weight;
    end
    if ((state == B_LN) && ln_done) ln_r <= ln_value;
    if (state == B_T1) begin
      yl_prod <= ymag * lnmag;
      lq_prod <= lnmag * lnmag;
      yl_neg <= y_r[31] ^ ln_r[LN_W-1];
    end
    if (state == B_T2) begin
      yl <= yl_neg ? -$signed({1'b0, yl_mag}) : $signed({1'b0, yl_mag});
      lq <= $signed({1'b0, lq_rnd[LQP_W:F]});
    end
    if (state == B_T3) begin
      t_ln <= {{(SUM_W-LN_W-17){p_ln[LN_W+16]}}, p_ln};
      t_yl <= {{(SUM_W-YL_W-17){p_yl[YL_W+16]}}, p_yl};
      t_y <= {{(SUM_W-49){p_y[48]}}, p_y};
      t_lq <= {{(SUM_W-LQ_W-17){p_lq[LQ_W+16]}}, p_lq};
    end
    if ((state == B_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {acc_count, sres.b_coef, sres.a_coef};
      m_tuser <= status;
    end
  end

endmodule

`default_nettype wire

// File: sv/log_regression_accumulator_top.sv
// top level of the log regression accumulator, fits y = A + B ln(x)
// depends on lra_pkg, lra_front, lra_back (which holds lra_ln and lra_solve)
//
// The block keeps saturating Q47.16 sums of w*ln x, w*y*ln x, w*y and
// w*(ln x)^2 plus a 40-bit total weight, and solves the least squares fit on
// finish. Each input transfer carries a command in s_tuser: clear, sample,
// merge or finish; only finish produces an output transfer (A, B, total count
// in m_tdata, status in m_tuser). Items are classified and queued in a two
// entry front queue, so upstream can run up to two items ahead while the back end works.
// In the back end, clear, merge and a sample with zero x are executed in the
// idle state as they are popped; a sample waits for the ln unit, which squares
// the mantissa once per cycle for each fraction bit, then passes the product,
// rounding and weighting states; finish runs the product sequence on one 32x32
// multiplier and two bit-serial divisions of W + 2 steps each, with
// W = 2*FRACTION_BITS + 130. A finished result waits in an output register
// while the next items are already being taken.
`default_nettype none

module log_regression_accumulator_top #(
  parameter int FRACTION_BITS = lra_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // x_value[31:0], y_value[63:32], weight[79:64], part_sum_log[143:80],
  // part_sum_ylog[207:144], part_sum_y[271:208], part_sum_logsq[335:272],
  // part_count[375:336]
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [lra_pkg::IN_DATA_W-1:0]   s_tdata,
  // cmd[1:0]
  input  wire logic [lra_pkg::IN_USER_W-1:0]   s_tuser,
  // a_coef[63:0], b_coef[127:64], total_count[167:128]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [lra_pkg::OUT_DATA_W-1:0]       m_tdata,
  // status[1:0]
  output logic [lra_pkg::OUT_USER_W-1:0]       m_tuser
);
  import lra_pkg::*;

  // queue head between front and back
  logic item_valid;
  item_t item;
  logic item_pop;

  // accept and classify each transfer
  lra_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // execute commands and drive the result register
  lra_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  // the back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid)
    else $error("queue popped while empty");

  // a degenerate fit reports zero coefficients
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_DEGENERATE)) |-> (m_tdata[127:0] == '0))
    else $error("degenerate result with nonzero coefficients");

  // backpressure upstream only while the queue holds items
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> item_valid)
    else $error("input stalled with empty queue");

endmodule

`default_nettype wire

// File: tb/lra_fit_checker.sv
// checker for the log regression accumulator: watches both stream channels,
// predicts every finish result from its own copy of the sums and compares
// depends on lra_pkg for command and status codes, ln 2 and the sum limits
`timescale 1ns / 1ps

module lra_fit_checker #(
  parameter int FB = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [lra_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [lra_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [lra_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic [lra_pkg::OUT_USER_W-1:0]  m_tuser,
  output int                              fail_count,
  output int                              pending,
  output int                              fits_checked
);
  import lra_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [63:0] a_coef;
    logic [63:0] b_coef;
    logic [39:0] total;
    logic [1:0]  status;
  } fit_t;

  fit_t fit_q[$];

  longint      sum_log, sum_ylog, sum_y, sum_logsq;
  logic [39:0] weight_total;
  bit          zero_x_seen, sum_saturated, quot_sat;

  function automatic longint round_shift(longint v, int sh);
    logic [63:0] mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // log2 by repeated squaring of the normalized mantissa, then times ln 2
  function automatic longint ln_fixed(logic [31:0] x);
    int          p;
    logic [63:0] m, fr;
    longint      lg;
    p = 31;
    while (p > 0 && !x[p]) p--;
    m = {32'd0, x} << (31 - p);
    fr = 0;
    for (int i = 0; i < FB; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= 64'h1_0000_0000) begin
        fr = fr | 64'd1;
        m = m >> 1;
      end
    end
    lg = longint'(p - FB) * (longint'(1) << FB) + longint'(fr);
    return round_shift(lg * longint'({32'd0, LN2_Q32}), 32);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      sum_saturated = 1;
      return s[64] ? SUM_MIN : SUM_MAX;
    end
    return s[63:0];
  endfunction

  function automatic void add_count(logic [39:0] c);
    logic [40:0] s;
    s = {1'b0, weight_total} + {1'b0, c};
    if (s[40]) begin
      weight_total = '1;
      sum_saturated = 1;
    end else begin
      weight_total = s[39:0];
    end
  endfunction

  // rounded half away from zero, saturated to 64 bits
  function automatic logic [63:0] div_round(wide_t num, wide_t den);
    logic [255:0] an, ad, q, lim;
    bit           neg;
    neg = ((num < 0) != (den < 0)) && (num != 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = ((an << 1) + ad) / (ad << 1);
    lim = neg ? 256'h8000_0000_0000_0000 : 256'h7FFF_FFFF_FFFF_FFFF;
    if (q > lim) begin
      q = lim;
      quot_sat = 1;
    end
    return neg ? -q[63:0] : q[63:0];
  endfunction

  function automatic fit_t solve_fit();
    fit_t  r;
    wide_t n, s0, s1, s2, s3, scale, den, nb, na;
    n = $signed({216'd0, weight_total});
    s0 = wide_t'(sum_log);
    s1 = wide_t'(sum_ylog);
    s2 = wide_t'(sum_y);
    s3 = wide_t'(sum_logsq);
    scale = wide_t'(1);
    scale = scale << FB;
    den = n * s3 * scale - s0 * s0;
    r.a_coef = '0;
    r.b_coef = '0;
    r.total = weight_total;
    quot_sat = 0;
    if (weight_total == 0 || den == 0) begin
      r.status = ST_DEGENERATE;
    end else begin
      nb = (n * s1 * scale - s2 * s0) * scale;
      na = (s2 * s3 - s0 * s1) * scale;
      r.b_coef = div_round(nb, den);
      r.a_coef = div_round(na, den);
      if (sum_saturated || quot_sat) r.status = ST_OVERFLOW;
      else if (zero_x_seen) r.status = ST_ZERO_X;
      else r.status = ST_OK;
    end
    return r;
  endfunction

  function automatic void clear_sums();
    sum_log = 0;
    sum_ylog = 0;
    sum_y = 0;
    sum_logsq = 0;
    weight_total = '0;
    zero_x_seen = 0;
    sum_saturated = 0;
  endfunction

  function automatic void take_item(logic [1:0] cmd, logic [375:0] d);
    longint yv, wv, lnx, yl, lq;
    case (cmd)
      CMD_CLEAR: clear_sums();
      CMD_SAMPLE: begin
        if (d[31:0] == 0) begin
          zero_x_seen = 1;
        end else begin
          yv = longint'(signed'(d[63:32]));
          wv = longint'({48'd0, d[79:64]});
          lnx = ln_fixed(d[31:0]);
          yl = round_shift(yv * lnx, FB);
          lq = round_shift(lnx * lnx, FB);
          sum_log = add_sat(sum_log, wv * lnx);
          sum_ylog = add_sat(sum_ylog, wv * yl);
          sum_y = add_sat(sum_y, wv * yv);
          sum_logsq = add_sat(sum_logsq, wv * lq);
          add_count({24'd0, d[79:64]});
        end
      end
      CMD_MERGE: begin
        sum_log = add_sat(sum_log, d[143:80]);
        sum_ylog = add_sat(sum_ylog, d[207:144]);
        sum_y = add_sat(sum_y, d[271:208]);
        sum_logsq = add_sat(sum_logsq, d[335:272]);
        add_count(d[375:336]);
      end
      default: fit_q.push_back(solve_fit());
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: fit %0d %s got %h want %h", $realtime, fits_checked, field, got, want);
    fail_count++;
  endtask

  task automatic check_fit();
    fit_t want;
    if (fit_q.size() == 0) begin
      $display("%0t: unexpected result transfer %h", $realtime, m_tdata);
      fail_count++;
      return;
    end
    want = fit_q.pop_front();
    if (m_tdata[63:0] !== want.a_coef) report_mismatch("a_coef", m_tdata[63:0], want.a_coef);
    if (m_tdata[127:64] !== want.b_coef)
      report_mismatch("b_coef", m_tdata[127:64], want.b_coef);
    if (m_tdata[167:128] !== want.total)
      report_mismatch("total_count", m_tdata[167:128], want.total);
    if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
    fits_checked++;
  endtask

  initial begin
    fail_count = 0;
    fits_checked = 0;
    pending = 0;
    clear_sums();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_sums();
    end else begin
      if (s_tvalid && s_tready) take_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_fit();
    end
    pending = fit_q.size();
  end

endmodule

// File: tb/tb_log_regression_accumulator_top.sv
// testbench top for the log regression accumulator: clock, reset, stimulus,
// receiver stalls, watchdog and verdict; depends on lra_pkg, lra_fit_checker
// and the block itself
`timescale 1ns / 1ps

module tb_log_regression_accumulator_top;
  import lra_pkg::*;

  localparam int FB = 16;
  localparam int STALL_LIMIT = 20000;  // cycles without any transfer
  localparam int HOLD_CYCLES = 1500;   // long receiver hold-off
  localparam int RAND_ITEMS = 650;

  logic                   clk = 0;
  logic                   rst = 1;
  logic                   s_tvalid = 0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;   // x, y, weight, four partial sums, count
  logic [IN_USER_W-1:0]   s_tuser = CMD_CLEAR;  // cmd
  logic                   m_tvalid;
  logic                   m_tready = 0;
  logic [OUT_DATA_W-1:0]  m_tdata;        // a_coef, b_coef, total_count
  logic [OUT_USER_W-1:0]  m_tuser;        // status

  int fail_count, pending, fits_checked;
  int tx_idle_pct = 22;
  int rx_idle_pct = 88;
  int sent = 0;
  int stall_cycles = 0;
  bit hold_go = 0;
  bit hold_taken = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  log_regression_accumulator_top #(.FRACTION_BITS(FB)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  lra_fit_checker #(.FB(FB)) chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending), .fits_checked(fits_checked)
  );

  // receiver: one long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("log_regression_accumulator_top: mismatch");
        $finish;
      end
    end
  end

  function automatic logic [375:0] pack_item(logic [31:0] x, logic [31:0] y,
      logic [15:0] w, logic [63:0] p0, logic [63:0] p1, logic [63:0] p2,
      logic [63:0] p3, logic [39:0] pc);
    return {pc, p3, p2, p1, p0, w, y, x};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [375:0] noise_data();
    return pack_item($urandom, $urandom, 16'($urandom), rand64(), rand64(), rand64(),
                     rand64(), {8'($urandom), $urandom});
  endfunction

  // one transfer on the input side, with random idle cycles ahead of it
  task automatic put_item(logic [1:0] cmd, logic [375:0] d);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic put_sample(logic [31:0] x, logic [31:0] y, logic [15:0] w);
    logic [375:0] d;
    d = noise_data();
    d[79:0] = {w, y, x};
    put_item(CMD_SAMPLE, d);
  endtask

  task automatic put_merge(logic [63:0] p0, logic [63:0] p1, logic [63:0] p2,
      logic [63:0] p3, logic [39:0] pc);
    logic [375:0] d;
    d = noise_data();
    d[375:80] = {pc, p3, p2, p1, p0};
    put_item(CMD_MERGE, d);
  endtask

  // a random run: mostly clear, random samples, maybe merges, finish; sometimes one random command
  task automatic random_run();
    int          k;
    logic [31:0] x, y;
    logic [15:0] w;
    if ($urandom_range(0, 9) == 0) begin
      put_item(2'($urandom), noise_data());
      return;
    end
    if ($urandom_range(0, 9) != 0) put_item(CMD_CLEAR, noise_data());
    k = $urandom_range(1, 10);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(0, 19))
        0:         x = 0;
        1, 2, 3:   x = $urandom_range(1, 255);
        4, 5, 6, 7, 8, 9, 10: x = $urandom_range(32'h1000, 32'h10_0000);
        default:   x = $urandom;
      endcase
      if ($urandom_range(0, 9) < 6) y = 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      else y = $urandom;
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        1, 2:    w = 16'($urandom);
        default: w = 16'($urandom_range(1, 16));
      endcase
      put_sample(x, y, w);
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 4) == 0)
          put_merge(rand64(), rand64(), rand64(), rand64(), {8'($urandom), $urandom});
        else
          put_merge(64'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23),
                    64'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23),
                    64'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23),
                    64'($urandom_range(0, 2 ** 24)), 40'($urandom_range(0, 64)));
      end
    end
    put_item(CMD_FINISH, noise_data());
    if ($urandom_range(0, 9) == 0) put_item(CMD_FINISH, noise_data());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty fit, ln of one, extreme x, y and weight, zero x,
    // saturating merge, count saturation, zero weight, ordinary fit
    put_item(CMD_CLEAR, '0);
    put_item(CMD_FINISH, '0);
    put_sample(32'h0001_0000, 32'h0000_0000, 16'd1);
    put_sample(32'h0000_0001, 32'h8000_0000, 16'hFFFF);
    put_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    put_sample(32'h0000_0000, 32'h0001_0000, 16'd3);
    put_item(CMD_FINISH, '0);
    put_merge(SUM_MAX, SUM_MAX, SUM_MAX, SUM_MAX, '1);
    put_item(CMD_FINISH, '0);
    put_item(CMD_CLEAR, '1);
    put_sample(32'h0002_0000, 32'h0003_0000, 16'd2);
    put_sample(32'h0008_0000, 32'hFFFE_8000, 16'd5);
    put_sample(32'h0000_4000, 32'h0000_1000, 16'd1);
    put_item(CMD_FINISH, '1);
    put_merge(SUM_MIN, SUM_MIN, SUM_MIN, SUM_MIN, 40'd0);
    put_item(CMD_FINISH, '0);
    put_item(CMD_CLEAR, '0);
    put_sample(32'h0001_0000, 32'h0001_0000, 16'd0);
    put_item(CMD_FINISH, '0);
    put_sample(32'h0003_0000, 32'h0001_0000, 16'd4);
    put_sample(32'h0003_0000, 32'h0002_0000, 16'd4);
    put_item(CMD_FINISH, '0);

    // random runs in three idle phases, long receiver hold-off in the last
    while (sent < 22 + RAND_ITEMS) begin
      if (sent > 22 + 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go <= 1;
      end else if (sent > 22 + RAND_ITEMS / 3) begin
        tx_idle_pct = 88;
        rx_idle_pct = 22;
      end
      random_run();
    end
    s_tvalid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("run covered %0d input transfers and %0d checked fits", sent, fits_checked);
    $display("fits spanned empty, zero-x, saturated and ordinary sums under stalls");
    if (fail_count == 0) begin
      $display("log_regression_accumulator_top: match");
    end else begin
      $display("log_regression_accumulator_top: mismatch");
    end
    $finish;
  end

endmodule
